FILE: hdl/lnre_pkg.sv
// Shared types and constants for the longest name-run extractor.
// No dependencies; used by lnre_scan, lnre_emit and the top level.
`timescale 1ns / 1ps

package lnre_pkg;

  localparam int unsigned MaxChars = 8;    // characters in one emitted name
  localparam int unsigned CountW   = 4;    // holds 0..MaxChars
  localparam logic [7:0]  ChSpace  = 8'h20;
  localparam logic [7:0]  ChDot    = 8'h2E;
  localparam logic [7:0]  ChLowA   = 8'h61;
  localparam logic [7:0]  ChLowZ   = 8'h7A;
  localparam logic [7:0]  ChUpA    = 8'h41;
  localparam logic [7:0]  ChUpZ    = 8'h5A;
  localparam logic [7:0]  ChZero   = 8'h30;
  localparam logic [7:0]  ChNine   = 8'h39;
  localparam logic [7:0]  CaseBit  = 8'h20;

  // Name handed from the scanner to the emitter at the end of a window.
  typedef struct packed {
    logic                            found;
    logic [CountW-1:0]               count;
    logic [MaxChars-1:0][7:0]        chars;
  } lnre_name_t;

endpackage

FILE: hdl/lnre_scan.sv
// Window scanner: tracks the open and best name runs per byte.
// Depends on lnre_pkg; hands a finished name to lnre_emit.
`timescale 1ns / 1ps

module lnre_scan import lnre_pkg::*; #(
  parameter int unsigned WINDOW_BYTES = 256,
  parameter int unsigned NAME_CHARS   = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             byte_valid_i,
  input  logic [7:0]       data_byte_i,
  input  logic [63:0]      default_name_i,
  output logic             last_byte_o,
  output logic             name_valid_o,
  output lnre_name_t       name_o
);

  localparam int unsigned PosW = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
  localparam int unsigned LenW = $clog2(WINDOW_BYTES + 1);
  localparam int unsigned CntW = $clog2(NAME_CHARS + 1);
  localparam logic [PosW-1:0] LastPos = PosW'(WINDOW_BYTES - 1);

  logic [PosW-1:0]                  pos_q, pos_d;
  logic [LenW-1:0]                  cur_len_q, cur_len_d;
  logic [LenW-1:0]                  best_len_q, best_len_d;
  logic [CntW-1:0]                  cur_cnt_q, cur_cnt_d;
  logic [CntW-1:0]                  best_cnt_q, best_cnt_d;
  logic [NAME_CHARS-1:0][7:0]       cur_cap_q, cur_cap_d;
  logic [NAME_CHARS-1:0][7:0]       best_cap_q, best_cap_d;

  logic                             is_name, keep, close, wins;
  logic [7:0]                       up_char;
  logic [LenW-1:0]                  cand_len, final_len;
  logic [CntW-1:0]                  cand_cnt, final_cnt;
  logic [NAME_CHARS-1:0][7:0]       cand_cap, final_cap;
  logic [CountW-1:0]                dflt_cnt;
  logic                             dflt_stop;

  assign last_byte_o = (pos_q == LastPos);

  always_comb begin
    is_name = ((data_byte_i >= ChLowA) && (data_byte_i <= ChLowZ)) ||
              ((data_byte_i >= ChUpA)  && (data_byte_i <= ChUpZ))  ||
              ((data_byte_i >= ChZero) && (data_byte_i <= ChNine)) ||
              (data_byte_i == ChSpace) || (data_byte_i == ChDot);
    keep    = is_name && (data_byte_i != ChSpace) && (data_byte_i != ChDot) &&
              (cur_cnt_q < CntW'(NAME_CHARS));
    up_char = ((data_byte_i >= ChLowA) && (data_byte_i <= ChLowZ)) ?
              (data_byte_i & ~CaseBit) : data_byte_i;

    // Open run after this byte (unchanged when the byte breaks the run).
    cand_len = is_name ? (cur_len_q + LenW'(1)) : cur_len_q;
    cand_cnt = keep ? (cur_cnt_q + CntW'(1)) : cur_cnt_q;
    for (int k = 0; k < NAME_CHARS; k++) begin
      cand_cap[k] = (keep && (cur_cnt_q == CntW'(k))) ? up_char : cur_cap_q[k];
    end

    // Close the run on a break or at the window's last byte; earlier run wins ties.
    close = !is_name || last_byte_o;
    wins  = cand_len > best_len_q;
    if (close && wins) begin
      final_len = cand_len;
      final_cnt = cand_cnt;
      final_cap = cand_cap;
    end else begin
      final_len = best_len_q;
      final_cnt = best_cnt_q;
      final_cap = best_cap_q;
    end

    // Length of the fallback name: up to its first zero byte.
    dflt_cnt  = '0;
    dflt_stop = 1'b0;
    for (int k = 0; k < MaxChars; k++) begin
      if (!dflt_stop && (default_name_i[8*k +: 8] != 8'h00)) begin
        dflt_cnt = dflt_cnt + CountW'(1);
      end else begin
        dflt_stop = 1'b1;
      end
    end

    pos_d      = pos_q;
    cur_len_d  = cur_len_q;
    cur_cnt_d  = cur_cnt_q;
    cur_cap_d  = cur_cap_q;
    best_len_d = best_len_q;
    best_cnt_d = best_cnt_q;
    best_cap_d = best_cap_q;
    if (byte_valid_i) begin
      if (last_byte_o) begin
        pos_d      = '0;
        cur_len_d  = '0;
        cur_cnt_d  = '0;
        best_len_d = '0;
        best_cnt_d = '0;
      end else begin
        pos_d      = pos_q + PosW'(1);
        best_len_d = final_len;
        best_cnt_d = final_cnt;
        best_cap_d = final_cap;
        if (close) begin
          cur_len_d = '0;
          cur_cnt_d = '0;
        end else begin
          cur_len_d = cand_len;
          cur_cnt_d = cand_cnt;
          cur_cap_d = cand_cap;
        end
      end
    end
  end

  // Finished name for the emitter.
  assign name_valid_o = byte_valid_i && last_byte_o;
  assign name_o.found = (final_len != '0);
  assign name_o.count = name_o.found ? CountW'(final_cnt) : dflt_cnt;

  for (genvar g = 0; g < MaxChars; g++) begin : g_chars
    if (g < NAME_CHARS) begin : g_cap
      assign name_o.chars[g] = name_o.found ? final_cap[g] : default_name_i[8*g +: 8];
    end else begin : g_dflt
      assign name_o.chars[g] = default_name_i[8*g +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      cur_len_q  <= '0;
      cur_cnt_q  <= '0;
      best_len_q <= '0;
      best_cnt_q <= '0;
    end else begin
      pos_q      <= pos_d;
      cur_len_q  <= cur_len_d;
      cur_cnt_q  <= cur_cnt_d;
      best_len_q <= best_len_d;
      best_cnt_q <= best_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_cap_q  <= cur_cap_d;
    best_cap_q <= best_cap_d;
  end

endmodule

FILE: hdl/lnre_emit.sv
// Name emitter: holds one finished name and streams its characters and terminator.
// Depends on lnre_pkg; fed by lnre_scan.
`timescale 1ns / 1ps

module lnre_emit import lnre_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             name_valid_i,
  input  lnre_name_t       name_i,
  output logic             busy_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       name_char_o,
  output logic             run_found_o,
  output logic             end_of_name_o
);

  logic                    busy_q, busy_d;
  logic [CountW-1:0]       idx_q, idx_d;
  lnre_name_t              name_q, name_d;
  logic                    at_end;

  assign at_end        = !(idx_q < name_q.count);
  assign busy_o        = busy_q;
  assign out_valid_o   = busy_q;
  assign name_char_o   = at_end ? 8'h00 : name_q.chars[idx_q[2:0]];
  assign run_found_o   = name_q.found;
  assign end_of_name_o = at_end;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    name_d = name_q;
    if (name_valid_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      name_d = name_i;
    end else if (busy_q && out_ready_i) begin
      // Advance to the next character, drop the name after its terminator.
      if (at_end) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    name_q <= name_d;
  end

endmodule

FILE: hdl/longest_name_run_extractor.sv
// Top level of the longest name-run extractor: config register, scanner, emitter.
// Depends on lnre_pkg, lnre_scan and lnre_emit.
`timescale 1ns / 1ps

//  channel | valid / ready            | payload
//  --------+--------------------------+----------------------------------------
//  input   | in_valid_i / in_ready_o  | data_byte_i[7:0]
//  config  | cfg_valid_i / cfg_ready_o| default_name_i[63:0]
//  output  | out_valid_o / out_ready_i| name_char_o[7:0], run_found_o, end_of_name_o
//
//  One input byte is taken per cycle; the scan state updates in the cycle of the
//  transaction. The window's last byte hands the finished name to the emitter,
//  which sends one character per cycle while out_ready_i is high and then the
//  terminator (up to nine transactions). The emitter holds one name: the last
//  byte of the next window waits while the previous name is still being sent; all
//  other bytes flow on. Reset (rst_ni, asynchronous, active low) clears positions,
//  lengths, counts, fallback name, emitter busy flag and index; stored names stay as is.
module longest_name_run_extractor import lnre_pkg::*; #(
  parameter int unsigned WINDOW_BYTES = 256,
  parameter int unsigned NAME_CHARS   = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] default_name_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  name_char_o,
  output logic        run_found_o,
  output logic        end_of_name_o
);

  logic [63:0]  default_name_q;
  logic         last_byte;
  logic         emit_busy;
  logic         byte_take;
  logic         name_valid;
  lnre_name_t   name;

  // Config register: always ready, hold the fallback name.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_name_q <= '0;
    end else if (cfg_valid_i) begin
      default_name_q <= default_name_i;
    end
  end

  // Stall only the window's last byte while the emitter still owns a name.
  assign in_ready_o = !(last_byte && emit_busy);
  assign byte_take  = in_valid_i && in_ready_o;

  lnre_scan #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .NAME_CHARS   (NAME_CHARS)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_valid_i   (byte_take),
    .data_byte_i    (data_byte_i),
    .default_name_i (default_name_q),
    .last_byte_o    (last_byte),
    .name_valid_o   (name_valid),
    .name_o         (name)
  );

  lnre_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .name_valid_i  (name_valid),
    .name_i        (name),
    .busy_o        (emit_busy),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .name_char_o   (name_char_o),
    .run_found_o   (run_found_o),
    .end_of_name_o (end_of_name_o)
  );

endmodule

FILE: dv/longest_name_run_extractor_test.sv
// Self-checking testbench for longest_name_run_extractor: streams 256-byte windows
// (a directed table, a back-pressure phase, then random windows) and checks each
// name transaction against a predictor. Depends on lnre_pkg and the RTL top level.
`timescale 1ns / 1ps

module longest_name_run_extractor_test;
  import lnre_pkg::*;

  localparam int unsigned WindowLen    = 256;
  localparam int unsigned SettleCycles = 6;      // emitter drain after the last result
  localparam int unsigned LongStall    = 600;    // receiver hold-off, in cycles
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned RunLimitNs   = 5_000_000;
  localparam int unsigned RandItems    = 310;

  // Run patterns, first character in the low byte, repeated every eight bytes.
  localparam logic [63:0] PatLower  = 64'h6867_6665_6463_6261;  // abcdefgh
  localparam logic [63:0] PatAlpha  = 64'h4847_4645_4443_4241;  // ABCDEFGH
  localparam logic [63:0] PatUpper  = 64'h5857_5655_5453_5251;  // QRSTUVWX
  localparam logic [63:0] PatBlank  = 64'h2E20_2E20_2E20_2E20;  // " . . . ."
  localparam logic [63:0] PatTie    = 64'h7A7A_3930_2E39_7A7A;  // zz9.09zz
  localparam logic [63:0] PatDigits = 64'h7A61_3930_7A61_3930;  // 09az09az
  localparam logic [63:0] PatMixed  = 64'h307A_5A2E_2031_6241;  // Ab1 .Zz0
  localparam logic [63:0] PatShort  = 64'h395A_2E39_5A2E_395A;  // Z9.Z9.Z9
  localparam logic [63:0] PatSpread = 64'h7170_396F_206E_2E6D;  // m.n o9pq
  localparam logic [63:0] PatLong   = 64'h454D_414E_474E_4F4C;  // LONGNAME

  typedef struct packed {
    logic [7:0] ch;
    logic       found;
    logic       last;
  } name_item_t;

  // One directed window: an optional fallback write, a fill byte, up to two runs,
  // and, where it is obvious, the name that must come out.
  typedef struct packed {
    logic        cfg_we;
    logic [63:0] cfg_val;
    logic [7:0]  fill;
    logic [63:0] pat_a;
    logic [8:0]  pos_a;
    logic [8:0]  len_a;
    logic [63:0] pat_b;
    logic [8:0]  pos_b;
    logic [8:0]  len_b;
    logic        typed;
    logic [3:0]  want_n;
    logic [63:0] want_chars;
    logic        want_found;
  } window_case_t;

  typedef enum int unsigned {
    KindRuns, KindBlank, KindTail, KindNoise, KindQuiet, KindDense
  } window_kind_t;

  localparam window_case_t DirectedWindows [11] = '{
    // after reset: zero fallback, no run -> terminator alone
    '{1'b0, 64'h0, 8'h00, 64'h0, 9'd0, 9'd0, 64'h0, 9'd0, 9'd0,
      1'b1, 4'd0, 64'h0, 1'b0},
    // short fallback "ABC", all-ones bytes
    '{1'b1, 64'h0000_0000_0043_4241, 8'hFF, 64'h0, 9'd0, 9'd0, 64'h0, 9'd0, 9'd0,
      1'b1, 4'd3, 64'h0043_4241, 1'b0},
    // full eight-character fallback of 0xFF
    '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 8'h80, 64'h0, 9'd0, 9'd0, 64'h0, 9'd0, 9'd0,
      1'b1, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
    // zero byte in the middle of the fallback cuts it short
    '{1'b1, 64'h4847_4600_4443_4241, 8'h7F, 64'h0, 9'd0, 9'd0, 64'h0, 9'd0, 9'd0,
      1'b1, 4'd4, 64'h4443_4241, 1'b0},
    // lower case folded, capture stops at eight
    '{1'b0, 64'h0, 8'h40, PatLower, 9'd10, 9'd12, PatAlpha, 9'd60, 9'd3,
      1'b0, 4'd0, 64'h0, 1'b0},
    // longest run holds only spaces and dots -> terminator alone, found
    '{1'b0, 64'h0, 8'h5B, PatBlank, 9'd30, 9'd5, PatShort, 9'd100, 9'd2,
      1'b1, 4'd0, 64'h0, 1'b1},
    // equal lengths: the earlier run wins
    '{1'b0, 64'h0, 8'h60, PatTie, 9'd20, 9'd6, PatUpper, 9'd200, 9'd6,
      1'b0, 4'd0, 64'h0, 1'b0},
    // longest run still open at the window's last byte
    '{1'b0, 64'h0, 8'h3A, PatDigits, 9'd250, 9'd6, PatAlpha, 9'd40, 9'd5,
      1'b0, 4'd0, 64'h0, 1'b0},
    // the whole window is one run
    '{1'b0, 64'h0, 8'h00, PatMixed, 9'd0, 9'd256, 64'h0, 9'd0, 9'd0,
      1'b0, 4'd0, 64'h0, 1'b0},
    // run at byte zero, longer mixed run later
    '{1'b0, 64'h0, 8'h7B, PatShort, 9'd0, 9'd3, PatSpread, 9'd100, 9'd20,
      1'b0, 4'd0, 64'h0, 1'b0},
    // fallback cleared again, no run
    '{1'b1, 64'h0, 8'h2F, 64'h0, 9'd0, 9'd0, 64'h0, 9'd0, 9'd0,
      1'b1, 4'd0, 64'h0, 1'b0}
  };

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i    = 8'h00;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [63:0] default_name_i = 64'h0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [7:0]  name_char_o;
  logic        run_found_o;
  logic        end_of_name_o;

  // Predictor state: a private copy of the scan and of the fallback register.
  logic [63:0]       fallback_name = 64'h0;
  int unsigned       scan_pos      = 0;
  logic [8:0]        open_len      = '0;
  logic [8:0]        best_len      = '0;
  logic [CountW-1:0] open_cnt      = '0;
  logic [CountW-1:0] best_cnt      = '0;
  logic [7:0]        open_cap [MaxChars];
  logic [7:0]        best_cap [MaxChars];
  bit                typed_window  = 1'b0;

  name_item_t  names_due [$];
  int unsigned mismatches     = 0;
  bit          sender_burst   = 1'b0;
  bit          recv_burst     = 1'b0;
  bit          long_stall_req = 1'b0;
  logic [7:0]  window_buf [WindowLen];

  always #5 clk_i = ~clk_i;

  longest_name_run_extractor #(
    .WINDOW_BYTES (WindowLen),
    .NAME_CHARS   (MaxChars)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .default_name_i (default_name_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .name_char_o    (name_char_o),
    .run_found_o    (run_found_o),
    .end_of_name_o  (end_of_name_o)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_name_char(input logic [7:0] b);
    return (b >= ChLowA && b <= ChLowZ) || (b >= ChUpA && b <= ChUpZ) ||
           (b >= ChZero && b <= ChNine) || b == ChSpace || b == ChDot;
  endfunction

  task automatic queue_name_item(input logic [7:0] ch, input logic found,
                                 input logic last);
    names_due.push_back({ch, found, last});
  endtask

  // Close the open run; keep it only if strictly longer, so ties go to the earlier run.
  task automatic close_open_run();
    if (open_len > best_len) begin
      best_len = open_len;
      best_cnt = open_cnt;
      best_cap = open_cap;
    end
    open_len = '0;
    open_cnt = '0;
  endtask

  // Advance the scan by one accepted byte; queue the name at the window's end.
  task automatic track_name_byte(input logic [7:0] b);
    if (is_name_char(b)) begin
      open_len = open_len + 9'd1;
      if (b != ChSpace && b != ChDot && open_cnt < MaxChars) begin
        open_cap[open_cnt] = (b >= ChLowA && b <= ChLowZ) ? (b & ~CaseBit) : b;
        open_cnt = open_cnt + 1'b1;
      end
    end else begin
      close_open_run();
    end
    scan_pos++;
    if (scan_pos == WindowLen) begin
      close_open_run();
      if (!typed_window) begin
        if (best_len != 0) begin
          for (int i = 0; i < best_cnt; i++) queue_name_item(best_cap[i], 1'b1, 1'b0);
          queue_name_item(8'h00, 1'b1, 1'b1);
        end else begin
          for (int i = 0; i < MaxChars; i++) begin
            if (fallback_name[8*i +: 8] == 8'h00) break;
            queue_name_item(fallback_name[8*i +: 8], 1'b0, 1'b0);
          end
          queue_name_item(8'h00, 1'b0, 1'b1);
        end
      end
      scan_pos = 0;
      best_len = '0;
      best_cnt = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] rand_name_char();
    int unsigned r;
    r = $urandom_range(0, 63);
    if (r < 26) return ChUpA + 8'(r);
    if (r < 52) return ChLowA + 8'(r - 26);
    if (r < 62) return ChZero + 8'(r - 52);
    return (r == 62) ? ChSpace : ChDot;
  endfunction

  function automatic logic [7:0] rand_other_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_name_char(b));
    return b;
  endfunction

  function automatic logic [63:0] rand_name_pat(input bit blank);
    logic [63:0] pat;
    for (int k = 0; k < 8; k++)
      pat[8*k +: 8] = blank ? (($urandom_range(0, 1) != 0) ? ChSpace : ChDot)
                            : rand_name_char();
    return pat;
  endfunction

  function automatic logic [63:0] pick_fallback();
    logic [63:0] v;
    int unsigned cut;
    v   = {$urandom, $urandom};
    cut = $urandom_range(0, 7);
    case ($urandom_range(0, 4))
      0:       v = '0;
      1:       v = '1;
      2:       v[8*cut +: 8] = 8'h00;
      default: ;
    endcase
    return v;
  endfunction

  // Overlay a run on the window, clipped at its end.
  task automatic place_run(input logic [63:0] pat, input int unsigned pos,
                           input int unsigned len);
    for (int unsigned k = 0; k < len && pos + k < WindowLen; k++)
      window_buf[pos + k] = pat[8*(k % 8) +: 8];
  endtask

  task automatic build_random_window(input window_kind_t kind);
    int unsigned runs, len, tie_len;
    for (int i = 0; i < WindowLen; i++)
      window_buf[i] = (kind == KindNoise) ? 8'($urandom_range(0, 255)) :
                      (kind == KindDense) ? rand_name_char() : rand_other_char();
    if (kind == KindDense)
      repeat ($urandom_range(1, 4)) window_buf[$urandom_range(0, WindowLen - 1)] =
                                      rand_other_char();
    if (kind == KindRuns || kind == KindBlank || kind == KindTail) begin
      runs    = $urandom_range(1, 5);
      // a shared length now and then makes ties likely
      tie_len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
      repeat (runs) begin
        if (tie_len != 0) len = tie_len;
        else len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
        place_run(rand_name_pat(kind == KindBlank), $urandom_range(0, WindowLen - 1), len);
      end
      if (kind == KindTail) begin
        len = $urandom_range(1, 30);
        place_run(rand_name_pat(1'b0), WindowLen - len, len);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers: everything changes at the falling edge, handshakes are seen at the
  // rising edge.
  // ---------------------------------------------------------------------------

  // Offer one byte after a random gap; hold it until the transaction completes.
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    track_name_byte(b);
    @(negedge clk_i);
  endtask

  task automatic stream_window();
    for (int i = 0; i < WindowLen; i++) push_byte(window_buf[i]);
  endtask

  // Drop valid and wait until every expected name has come out, plus drain time.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (names_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_fallback(input logic [63:0] v);
    cfg_valid_i    <= 1'b1;
    default_name_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    fallback_name = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    window_case_t row;
    window_kind_t kind;
    int unsigned  rand_items;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed windows: walk the table.
    foreach (DirectedWindows[r]) begin
      row = DirectedWindows[r];
      if (row.cfg_we) begin
        wait_drained();
        write_fallback(row.cfg_val);
      end
      foreach (window_buf[i]) window_buf[i] = row.fill;
      place_run(row.pat_a, row.pos_a, row.len_a);
      place_run(row.pat_b, row.pos_b, row.len_b);
      // Queue the obvious name now; the predictor only tracks state for this window.
      typed_window = row.typed;
      if (row.typed) begin
        for (int k = 0; k < row.want_n; k++)
          queue_name_item(row.want_chars[8*k +: 8], row.want_found, 1'b0);
        queue_name_item(8'h00, row.want_found, 1'b1);
      end
      sender_burst = ($urandom_range(0, 3) == 0);
      stream_window();
      typed_window = 1'b0;
    end

    // Back-pressure: stall the receiver for a long stretch while two windows stream
    // without gaps, so the second window's last byte has to wait for the emitter.
    wait_drained();
    long_stall_req = 1'b1;
    sender_burst   = 1'b1;
    repeat (2) begin
      build_random_window(KindRuns);
      place_run(PatLong, 100, 16);
      stream_window();
    end
    // Hold the sender until the receiver has taken every name.
    wait_drained();

    // Random windows, mostly well-formed runs; rewrite the fallback now and then.
    rand_items = 0;
    while (rand_items < RandItems) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: kind = KindRuns;
        4:          kind = KindBlank;
        5:          kind = KindTail;
        6:          kind = KindNoise;
        7, 8:       kind = KindQuiet;
        default:    kind = KindDense;
      endcase
      if ($urandom_range(0, 3) == 0) begin
        wait_drained();
        write_fallback(pick_fallback());
        // show the new fallback often
        if ($urandom_range(0, 1) != 0) kind = KindQuiet;
      end
      sender_burst = ($urandom_range(0, 3) == 0);
      build_random_window(kind);
      stream_window();
      rand_items += WindowLen;
    end

    wait_drained();
    if (mismatches == 0 && names_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver: a random stall before each transaction, bursts without stalls, and
  // one long hold-off on request.
  initial begin : name_sink
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      if (long_stall_req) begin
        stall          = LongStall;
        long_stall_req = 1'b0;
      end else begin
        stall = recv_burst ? 0 : $urandom_range(0, 3);
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      if (taken % 32 == 0) recv_burst = ($urandom_range(0, 2) == 0);
      @(negedge clk_i);
    end
  end

  // Compare each output transaction with the oldest expected name item.
  always @(posedge clk_i) begin : name_check
    name_item_t seen;
    name_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen = {name_char_o, run_found_o, end_of_name_o};
      if (names_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("ERROR %0t: unexpected transaction char=%h found=%b last=%b",
                   $time, seen.ch, seen.found, seen.last);
      end else begin
        want = names_due.pop_front();
        if (seen.ch !== want.ch || seen.found !== want.found || seen.last !== want.last)
        begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("ERROR %0t: expected char=%h found=%b last=%b, got char=%h found=%b last=%b",
                     $time, want.ch, want.found, want.last, seen.ch, seen.found, seen.last);
        end
      end
    end
  end

  initial begin : watchdog
    #(RunLimitNs);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
